/* hdl/assert_macros.svh */
// assertion macros for the neuron datapath top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next cycle");

`endif

/* hdl/nma_pkg.sv */
// shared constants, codes and the sigmoid lookup table for the neuron datapath
`default_nettype none

package nma_pkg;

   localparam int DATA_WIDTH      = 16;
   localparam int ACC_WIDTH       = 48;
   localparam int SIGMOID_ENTRIES = 256;
   localparam int FRAC_BITS       = 8;
   localparam int RAW_WIDTH       = 32;
   localparam int TAYLOR_TERMS    = 16;
   localparam int SIG_ENTRY_WIDTH = 16;
   localparam int SIG_RANGE_INT   = 8;

   localparam int TERM_WIDTH      = 2 * DATA_WIDTH + 1;
   localparam int ACC_EXT_WIDTH   = ACC_WIDTH + 1;
   localparam int SIG_IDX_WIDTH   = $clog2(SIGMOID_ENTRIES);
   localparam int SIG_SHIFT       = 2 * FRAC_BITS + $clog2(2 * SIG_RANGE_INT) - SIG_IDX_WIDTH;

   localparam int MODE_WIDTH      = 2;
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_IDX_WIDTH   = CSR_ADDR_WIDTH - 2;

   // activation modes (code 3 behaves as identity)
   localparam logic [MODE_WIDTH-1:0] MODE_NONE    = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_SIGMOID = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_RELU    = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_IDX_MODE = 1'b0;

   typedef logic [SIG_ENTRY_WIDTH-1:0] sig_table_type [SIGMOID_ENTRIES];

   // e^-n in Q32 for n = 0..8
   localparam logic [63:0] EXP_NEG_INT_Q32 [9] = '{
      64'd4294967296, 64'd1580030169, 64'd581260615, 64'd213833830, 64'd78665070,
      64'd28939262, 64'd10646158, 64'd3916504, 64'd1440801
   };

   // shift-and-subtract quotient, only used while the table is built
   function automatic logic [63:0] const_udiv(logic [63:0] num, logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // round(256 * logistic(m)) at the middle of each slot, integer arithmetic only
   function automatic logic [SIG_ENTRY_WIDTH-1:0] sigmoid_entry(int unsigned i);
      logic [63:0] t;
      logic [63:0] two35;
      logic        neg;
      logic [63:0] y;
      logic [63:0] n;
      logic [63:0] f;
      logic [63:0] term;
      longint      sum;
      logic [63:0] ef;
      logic [63:0] en;
      logic [63:0] e;
      logic [63:0] d;
      logic [63:0] num;
      logic [63:0] q;
      two35 = 64'd1 << 35;
      t     = (64'(2 * i + 1) << 35) >> SIG_IDX_WIDTH;
      neg   = t < two35;
      y     = neg ? two35 - t : t - two35;
      n     = y >> 32;
      f     = y & 64'hFFFF_FFFF;
      term  = 64'd1 << 32;
      sum   = longint'(term);
      for (int k = 1; k <= TAYLOR_TERMS; k++) begin
         term = const_udiv((term * f) >> 32, 64'(k));
         if ((k % 2) == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      ef = (sum < 0) ? 64'd0 : 64'(sum);
      if (ef > (64'd1 << 32)) ef = 64'd1 << 32;
      en  = EXP_NEG_INT_Q32[(n > 64'd8) ? 8 : int'(n)];
      e   = ((en >> 1) * ef) >> 31;
      d   = (64'd1 << 32) + e;
      num = neg ? (e << (FRAC_BITS + 1)) : (64'd1 << (32 + FRAC_BITS + 1));
      q   = const_udiv(num + d, d << 1);
      return q[SIG_ENTRY_WIDTH-1:0];
   endfunction

   function automatic sig_table_type build_sigmoid_table();
      sig_table_type tbl;
      for (int unsigned i = 0; i < SIGMOID_ENTRIES; i++) begin
         tbl[i] = sigmoid_entry(i);
      end
      return tbl;
   endfunction

   localparam sig_table_type SIGMOID_TABLE = build_sigmoid_table();

endpackage

`default_nettype wire

/* hdl/nma_req_if.sv */
// request channel: one connection term per transfer
`default_nettype none

interface nma_req_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [nma_pkg::DATA_WIDTH-1:0]     activation_in;
   logic signed [nma_pkg::DATA_WIDTH-1:0]     weight_in;
   logic signed [nma_pkg::DATA_WIDTH-1:0]     bias_in;
   logic                                      last_term;

   modport source (output valid, activation_in, weight_in, bias_in, last_term, input ready);
   modport sink   (input valid, activation_in, weight_in, bias_in, last_term, output ready);
endinterface

`default_nettype wire

/* hdl/nma_rsp_if.sv */
// response channel: finished neuron sum and activated value
`default_nettype none

interface nma_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [nma_pkg::RAW_WIDTH-1:0]      raw_sum;
   logic signed [nma_pkg::DATA_WIDTH-1:0]     activated_value;

   modport source (output valid, raw_sum, activated_value, input ready);
   modport sink   (input valid, raw_sum, activated_value, output ready);
endinterface

`default_nettype wire

/* hdl/nma_activate.sv */
// output formatting: 32-bit saturation of the sum and the selected activation
`default_nettype none

module nma_activate (
   input  wire logic signed [nma_pkg::ACC_WIDTH-1:0]  sum,
   input  wire logic        [nma_pkg::MODE_WIDTH-1:0] mode,
   output logic signed      [nma_pkg::RAW_WIDTH-1:0]  raw_sum,
   output logic signed      [nma_pkg::DATA_WIDTH-1:0] activated_value
);

   localparam int AW = nma_pkg::ACC_WIDTH;
   localparam int DW = nma_pkg::DATA_WIDTH;
   localparam int RW = nma_pkg::RAW_WIDTH;
   localparam int unsigned DATA_POS_MAX = 2 ** (DW - 1) - 1;
   localparam logic signed [AW-1:0] SIG_LIM =
      AW'(nma_pkg::SIG_RANGE_INT) <<< (2 * nma_pkg::FRAC_BITS);

   logic signed [DW-1:0]                          data_max;
   logic signed [DW-1:0]                          data_min;
   logic                                          raw_ovf;
   logic signed [AW-1:0]                          floored;
   logic                                          flr_ovf;
   logic signed [DW-1:0]                          lin_val;
   logic signed [AW-1:0]                          sig_offset;
   logic        [nma_pkg::SIG_IDX_WIDTH-1:0]      sig_idx;
   logic        [nma_pkg::SIG_ENTRY_WIDTH-1:0]    sig_entry;
   logic signed [DW-1:0]                          sig_val;

   assign data_max = {1'b0, {(DW-1){1'b1}}};
   assign data_min = {1'b1, {(DW-1){1'b0}}};

   // raw output clamps to the 32-bit range
   assign raw_ovf = sum[AW-1:RW-1] != {(AW-RW+1){sum[AW-1]}};
   always_comb begin
      if (raw_ovf) begin
         raw_sum = sum[AW-1] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
      end else begin
         raw_sum = sum[RW-1:0];
      end
   end

   // floor to q8.8 and clamp
   assign floored = sum >>> nma_pkg::FRAC_BITS;
   assign flr_ovf = floored[AW-1:DW-1] != {(AW-DW+1){floored[AW-1]}};
   always_comb begin
      if (flr_ovf) begin
         lin_val = floored[AW-1] ? data_min : data_max;
      end else begin
         lin_val = floored[DW-1:0];
      end
   end

   // sigmoid slot, clamped at both ends of [-8, 8)
   assign sig_offset = sum + SIG_LIM;
   always_comb begin
      if (sum < -SIG_LIM) begin
         sig_idx = '0;
      end else if (sum >= SIG_LIM) begin
         sig_idx = '1;
      end else begin
         sig_idx = sig_offset[nma_pkg::SIG_SHIFT +: nma_pkg::SIG_IDX_WIDTH];
      end
   end
   assign sig_entry = nma_pkg::SIGMOID_TABLE[sig_idx];
   assign sig_val   = (32'(sig_entry) > DATA_POS_MAX) ? data_max : DW'(sig_entry);

   always_comb begin
      case (mode)
         nma_pkg::MODE_NONE:    activated_value = lin_val;
         nma_pkg::MODE_SIGMOID: activated_value = sig_val;
         nma_pkg::MODE_RELU:    activated_value = sum[AW-1] ? '0 : lin_val;
         default:               activated_value = lin_val;
      endcase
   end

endmodule

`default_nettype wire

/* hdl/neuron_mac_activation.sv */
// neuron multiply-accumulate with selectable activation, top level
//
//   channel   direction  handshake        payload
//   req_chan  in         valid/ready      activation_in, weight_in, bias_in, last_term
//   rsp_chan  out        valid/ready      raw_sum, activated_value
//   csr_*     in/out     apb, pready=1    activation_mode at byte address 0
//
// one request per cycle sustained unless a response backs up into the finished-sum stage
// stages: input register, multiply register, accumulator, finished-sum register, output register
// each stage has its own ready, so requests keep flowing while a response waits at the output
// only a last request needs room in the finished-sum stage; others fold into the accumulator
// reset is synchronous and clears valid bits, the accumulator and the mode register
`default_nettype none
`include "assert_macros.svh"

module neuron_mac_activation (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   nma_req_if.sink                                     req_chan,
   nma_rsp_if.source                                   rsp_chan,
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [nma_pkg::CSR_ADDR_WIDTH-1:0]     csr_paddr,
   input  wire logic [nma_pkg::CSR_DATA_WIDTH-1:0]     csr_pwdata,
   output logic      [nma_pkg::CSR_DATA_WIDTH-1:0]     csr_prdata,
   output logic                                        csr_pready
);

   localparam int DW = nma_pkg::DATA_WIDTH;
   localparam int AW = nma_pkg::ACC_WIDTH;
   localparam int TW = nma_pkg::TERM_WIDTH;
   localparam int XW = nma_pkg::ACC_EXT_WIDTH;
   localparam int MW = nma_pkg::MODE_WIDTH;

   // stage 0: captured request
   logic                    s0_valid_ff, s0_valid_in;
   logic signed [DW-1:0]    s0_act_ff, s0_act_in;
   logic signed [DW-1:0]    s0_wgt_ff, s0_wgt_in;
   logic signed [DW-1:0]    s0_bias_ff, s0_bias_in;
   logic                    s0_last_ff, s0_last_in;
   // stage 1: product plus shifted bias
   logic                    s1_valid_ff, s1_valid_in;
   logic signed [TW-1:0]    s1_term_ff, s1_term_in;
   logic                    s1_last_ff, s1_last_in;
   // running sum
   logic signed [AW-1:0]    acc_ff, acc_in;
   // stage 2: finished sum of one neuron
   logic                    s2_valid_ff, s2_valid_in;
   logic signed [AW-1:0]    s2_sum_ff, s2_sum_in;
   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [nma_pkg::RAW_WIDTH-1:0] rsp_raw_ff, rsp_raw_in;
   logic signed [DW-1:0]    rsp_act_ff, rsp_act_in;
   // configuration
   logic [MW-1:0]           mode_ff, mode_in;

   logic                    ld_out, s2_free, mv1, s1_free, mv0, req_ready, accept;
   logic signed [2*DW-1:0]  product;
   logic signed [DW+nma_pkg::FRAC_BITS-1:0] bias_sh;
   logic signed [XW-1:0]    sum_wide;
   logic signed [AW-1:0]    sum_sat;
   logic signed [nma_pkg::RAW_WIDTH-1:0] fmt_raw;
   logic signed [DW-1:0]    fmt_act;
   logic                    csr_wr;
   logic [nma_pkg::CSR_IDX_WIDTH-1:0] csr_idx;

   // per-stage flow control, output backward to input
   assign ld_out    = s2_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign s2_free   = !s2_valid_ff || ld_out;
   assign mv1       = s1_valid_ff && (!s1_last_ff || s2_free);
   assign s1_free   = !s1_valid_ff || mv1;
   assign mv0       = s0_valid_ff && s1_free;
   assign req_ready = !s0_valid_ff || mv0;
   assign accept    = req_chan.valid && req_ready;

   assign req_chan.ready = req_ready;

   // q8.8 times q8.8 gives q16.16; bias moves up by the fraction width
   assign product = s0_act_ff * s0_wgt_ff;
   assign bias_sh = {s0_bias_ff, {nma_pkg::FRAC_BITS{1'b0}}};

   // saturating accumulate: one guard bit detects overflow
   assign sum_wide = XW'(acc_ff) + XW'(s1_term_ff);
   always_comb begin
      if (sum_wide[XW-1] != sum_wide[XW-2]) begin
         sum_sat = sum_wide[XW-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[AW-1:0];
      end
   end

   nma_activate u_activate (
      .sum             (s2_sum_ff),
      .mode            (mode_ff),
      .raw_sum         (fmt_raw),
      .activated_value (fmt_act)
   );

   // register port: single register at index 0
   assign csr_idx    = csr_paddr[nma_pkg::CSR_ADDR_WIDTH-1:2];
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_idx == nma_pkg::CSR_IDX_MODE) ?
                       nma_pkg::CSR_DATA_WIDTH'(mode_ff) : '0;

   always_comb begin
      s0_valid_in = s0_valid_ff;
      s0_act_in   = s0_act_ff;
      s0_wgt_in   = s0_wgt_ff;
      s0_bias_in  = s0_bias_ff;
      s0_last_in  = s0_last_ff;
      if (accept) begin
         s0_valid_in = 1'b1;
         s0_act_in   = req_chan.activation_in;
         s0_wgt_in   = req_chan.weight_in;
         s0_bias_in  = req_chan.bias_in;
         s0_last_in  = req_chan.last_term;
      end else if (mv0) begin
         s0_valid_in = 1'b0;
      end

      s1_valid_in = s1_valid_ff;
      s1_term_in  = s1_term_ff;
      s1_last_in  = s1_last_ff;
      if (mv0) begin
         s1_valid_in = 1'b1;
         s1_term_in  = TW'(product) + TW'(bias_sh);
         s1_last_in  = s0_last_ff;
      end else if (mv1) begin
         s1_valid_in = 1'b0;
      end

      // a last term closes the neuron and restarts the running sum
      acc_in      = acc_ff;
      s2_valid_in = s2_valid_ff;
      s2_sum_in   = s2_sum_ff;
      if (mv1 && s1_last_ff) begin
         acc_in      = '0;
         s2_valid_in = 1'b1;
         s2_sum_in   = sum_sat;
      end else begin
         if (mv1) begin
            acc_in = sum_sat;
         end
         if (ld_out) begin
            s2_valid_in = 1'b0;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_raw_in   = rsp_raw_ff;
      rsp_act_in   = rsp_act_ff;
      if (ld_out) begin
         rsp_valid_in = 1'b1;
         rsp_raw_in   = fmt_raw;
         rsp_act_in   = fmt_act;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      mode_in = mode_ff;
      if (csr_wr && csr_idx == nma_pkg::CSR_IDX_MODE) begin
         mode_in = csr_pwdata[MW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         mode_ff      <= nma_pkg::MODE_NONE;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         mode_ff      <= mode_in;
      end
      s0_act_ff  <= s0_act_in;
      s0_wgt_ff  <= s0_wgt_in;
      s0_bias_ff <= s0_bias_in;
      s0_last_ff <= s0_last_in;
      s1_term_ff <= s1_term_in;
      s1_last_ff <= s1_last_in;
      s2_sum_ff  <= s2_sum_in;
      rsp_raw_ff <= rsp_raw_in;
      rsp_act_ff <= rsp_act_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.raw_sum         = rsp_raw_ff;
   assign rsp_chan.activated_value = rsp_act_ff;

   // running sum restarts after each finished neuron
   `ASSERT_NEXT(a_acc_clear, clock, reset, mv1 && s1_last_ff, acc_ff == '0)
   // input stalls only when the first two stages are both occupied
   `ASSERT_IMPLY(a_stall_full, clock, reset, !req_ready, s0_valid_ff && s1_valid_ff)
   // a finished sum that cannot move on stays put
   `ASSERT_NEXT(a_sum_hold, clock, reset, s2_valid_ff && !ld_out,
                s2_valid_ff && $stable(s2_sum_ff))
   // relu output is never negative
   `ASSERT_IMPLY(a_relu_sign, clock, reset, rsp_valid_ff && mode_ff == nma_pkg::MODE_RELU,
                 !rsp_act_ff[DW-1])

endmodule

`default_nettype wire
